>>> rtl/core/dfts_pkg.sv
// ----------------------------------------------------------------------------
// dfts_pkg
// Shared widths and defaults of the DFR term score block.
// ----------------------------------------------------------------------------
`default_nettype none

package dfts_pkg;

  localparam int unsigned LOG_FRAC_BITS_DEF   = 24;
  localparam int unsigned SCORE_FRAC_BITS_DEF = 16;

  localparam int unsigned TF_W    = 16;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned CL_W    = 48;
  localparam int unsigned SCORE_W = 64;
  // integer part of a log2 value; arguments stay below 2^48
  localparam int unsigned EXP_W   = 6;
  // normalized mantissa, Q1.31
  localparam int unsigned MANT_W  = 32;

endpackage

`default_nettype wire

>>> rtl/core/dfts_if.sv
// ----------------------------------------------------------------------------
// dfts_in_if / dfts_out_if
// Valid/ready channels for postings in and scores out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfts_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] tf_count;
  logic [31:0] doc_length;

  modport source (output valid, output tf_count, output doc_length, input ready);
  modport sink   (input valid, input tf_count, input doc_length, output ready);
endinterface

interface dfts_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] score;
  logic        bad_operand;

  modport source (output valid, output score, output bad_operand, input ready);
  modport sink   (input valid, input score, input bad_operand, output ready);
endinterface

`default_nettype wire

>>> rtl/core/dfts_log2.sv
// ----------------------------------------------------------------------------
// dfts_log2
// Pipelined fixed-point log2 of an integer: a registered normalize, then one
// squaring stage per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module dfts_log2 #(
  parameter int unsigned XW            = 48,
  parameter int unsigned LOG_FRAC_BITS = dfts_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       en_i,
  input  wire logic [XW-1:0]                              x_i,
  output logic      [dfts_pkg::EXP_W+LOG_FRAC_BITS-1:0]   log_o
);
  import dfts_pkg::*;

  logic [MANT_W-1:0]        m_q [LOG_FRAC_BITS+1];
  logic [EXP_W-1:0]         e_q [LOG_FRAC_BITS+1];
  logic [LOG_FRAC_BITS-1:0] f_q [LOG_FRAC_BITS+1];

  logic [MANT_W-1:0] m0_d;
  logic [EXP_W-1:0]  e0_d;

  // leading one picks the alignment; zero reads as one
  always_comb begin
    logic [XW+MANT_W-1:0] tmp;
    e0_d = '0;
    m0_d = {1'b1, {(MANT_W-1){1'b0}}};
    for (int i = 0; i < XW; i++) begin
      tmp = {x_i, {MANT_W{1'b0}}} >> (i + 1);
      if (x_i[i]) begin
        e0_d = EXP_W'(i);
        m0_d = tmp[MANT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m0_d;
      e_q[0] <= e0_d;
      f_q[0] <= '0;
    end
  end

  for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    assign sq = m_q[g] * m_q[g];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[g+1] <= sq[2*MANT_W-1] ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];
        f_q[g+1] <= {f_q[g][LOG_FRAC_BITS-2:0], sq[2*MANT_W-1]};
        e_q[g+1] <= e_q[g];
      end
    end
  end

  assign log_o = {e_q[LOG_FRAC_BITS], f_q[LOG_FRAC_BITS]};

endmodule

`default_nettype wire

>>> rtl/core/dfree_term_score_top.sv
// Throughput: one request per cycle unless the output stalls; the log2 units square once per stage,
// one stage per fraction bit, and every stage advances together.
// A stalled output holds the whole pipeline; bubbles are not squeezed out.
// Reset clears the valid bits and sets collection_length to 1.
// ----------------------------------------------------------------------------
// dfree_term_score_top
// Parameter-free DFR term score, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module dfree_term_score_top #(
  parameter int unsigned LOG_FRAC_BITS   = dfts_pkg::LOG_FRAC_BITS_DEF,
  parameter int unsigned SCORE_FRAC_BITS = dfts_pkg::SCORE_FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [dfts_pkg::CL_W-1:0] cfg_wdata_i,
  dfts_in_if.sink                        in_if,
  dfts_out_if.source                     out_if
);
  import dfts_pkg::*;

  localparam int unsigned LOG_W = EXP_W + LOG_FRAC_BITS;
  localparam int unsigned LSW   = LOG_W + 2;        // signed log sums
  localparam int unsigned NW    = LSW + TF_W + 1;   // products with tf
  localparam int unsigned IW    = NW + 3;           // doubled bracket
  localparam int unsigned D     = LOG_FRAC_BITS + 1;
  localparam int unsigned NST   = D + 7;
  localparam int unsigned RS    = 2 * LOG_FRAC_BITS + 1 - SCORE_FRAC_BITS;

  logic [CL_W-1:0] cl_q;
  logic [NST-1:0]  vld_q;
  logic            en;

  assign en          = !vld_q[NST-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_q <= CL_W'(1);
    end else if (cfg_we_i) begin
      cl_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_if.valid};
    end
  end

  // --- log2 units ----------------------------------------------------------
  logic [LOG_W-1:0] la, lb, lc, ld, lg;

  dfts_log2 #(.XW(TF_W), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_la (
    .clk_i, .en_i(en), .x_i(in_if.tf_count), .log_o(la));
  dfts_log2 #(.XW(TF_W+1), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_lb (
    .clk_i, .en_i(en), .x_i({1'b0, in_if.tf_count} + (TF_W+1)'(1)), .log_o(lb));
  dfts_log2 #(.XW(LEN_W), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_lc (
    .clk_i, .en_i(en), .x_i(in_if.doc_length), .log_o(lc));
  dfts_log2 #(.XW(LEN_W+1), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_ld (
    .clk_i, .en_i(en), .x_i({1'b0, in_if.doc_length} + (LEN_W+1)'(1)), .log_o(ld));
  dfts_log2 #(.XW(CL_W), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_lg (
    .clk_i, .en_i(en), .x_i(cl_q), .log_o(lg));

  // side band alongside the log units
  logic [TF_W-1:0] tf_s  [D];
  logic            bad_s [D];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tf_s[0]  <= in_if.tf_count;
      bad_s[0] <= (in_if.tf_count == '0) || (in_if.doc_length == '0);
      for (int k = 1; k < D; k++) begin
        tf_s[k]  <= tf_s[k-1];
        bad_s[k] <= bad_s[k-1];
      end
    end
  end

  // --- combine -------------------------------------------------------------
  logic signed [LSW-1:0] p_q, q_q, r_q, r2_q;
  logic        [TF_W-1:0] tf1_q;
  logic signed [NW-1:0]  norm_q, norm3_q, a_q, b_q;
  logic signed [IW-1:0]  inner_q;
  logic [SCORE_W-1:0]    mn_q, mi_q;
  logic                  neg4_q, neg5_q, neg6_q;
  logic [2*SCORE_W-1:0]  p00_q, p01_q, p10_q, p11_q, prod_q;
  logic                  bad1_q, bad2_q, bad3_q, bad4_q, bad5_q, bad6_q;
  logic [SCORE_W-1:0]    score_q;
  logic                  bad7_q;

  logic signed [LSW-1:0] sa, sb, sc, sd, sg;
  logic signed [TF_W:0]  tfs;
  logic signed [TF_W+1:0] tfp1;
  logic signed [IW-1:0]  inner_d;
  logic [2*SCORE_W-1:0]  sh;
  logic [SCORE_W-1:0]    lim, mag;

  assign sa = LSW'(la);
  assign sb = LSW'(lb);
  assign sc = LSW'(lc);
  assign sd = LSW'(ld);
  assign sg = LSW'(lg);

  assign tfs  = $signed({1'b0, tf1_q});
  // one bit wider: tf+1 reaches 2^TF_W
  assign tfp1 = (TF_W+2)'(tfs) + (TF_W+2)'(1);

  assign inner_d = ((IW'(a_q) - IW'(b_q)) <<< 1) + IW'(r2_q);

  assign sh  = prod_q >> RS;
  assign lim = neg6_q ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};

  always_comb begin
    if (|sh[2*SCORE_W-1:SCORE_W]) begin
      mag = lim;
    end else if (sh[SCORE_W-1:0] > lim) begin
      mag = lim;
    end else begin
      mag = sh[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // log differences
      p_q    <= sg - sc;
      q_q    <= sb + sg - sa - sd;
      r_q    <= sb + sc - sa - sd;
      tf1_q  <= tf_s[D-1];
      bad1_q <= bad_s[D-1];
      // products with tf
      norm_q <= tfs * r_q;
      a_q    <= tfp1 * q_q;
      b_q    <= tfs * p_q;
      r2_q   <= r_q;
      bad2_q <= bad1_q;
      // doubled bracket, so the half weight stays exact
      inner_q <= inner_d;
      norm3_q <= norm_q;
      bad3_q  <= bad2_q;
      // sign and magnitudes
      neg4_q <= norm3_q[NW-1] != inner_q[IW-1];
      mn_q   <= SCORE_W'(norm3_q[NW-1] ? -norm3_q : norm3_q);
      mi_q   <= SCORE_W'(inner_q[IW-1] ? -inner_q : inner_q);
      bad4_q <= bad3_q;
      // 64x64 split into 32x32 partial products
      p00_q  <= (2*SCORE_W)'({32'd0, mn_q[31:0]}  * {32'd0, mi_q[31:0]});
      p01_q  <= (2*SCORE_W)'({32'd0, mn_q[31:0]}  * {32'd0, mi_q[63:32]});
      p10_q  <= (2*SCORE_W)'({32'd0, mn_q[63:32]} * {32'd0, mi_q[31:0]});
      p11_q  <= (2*SCORE_W)'({32'd0, mn_q[63:32]} * {32'd0, mi_q[63:32]});
      neg5_q <= neg4_q;
      bad5_q <= bad4_q;
      // sum with half-ulp rounding on the magnitude
      prod_q <= p00_q + (p01_q << 32) + (p10_q << 32) + (p11_q << 64)
              + ((2*SCORE_W)'(1) << (RS - 1));
      neg6_q <= neg5_q;
      bad6_q <= bad5_q;
      // saturate and sign
      score_q <= bad6_q ? '0 : (neg6_q ? -mag : mag);
      bad7_q  <= bad6_q;
    end
  end

  // r2_q only pipes r to the bracket stage
  assign out_if.valid       = vld_q[NST-1];
  assign out_if.score       = score_q;
  assign out_if.bad_operand = bad7_q;

endmodule

`default_nettype wire
